/* design/ergma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ergma_pkg: shared constants and types for the echo range gated average
// Field widths, register codes, reset values, the fixed-point constants of
// the microsecond to centimetre conversion and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package ergma_pkg;

    // Field widths
    localparam int DUR_W       = 16;
    localparam int DIST_W      = 11;
    localparam int AVG_W       = 12;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int CFG_IDX_W   = 1;

    // Window length default
    localparam int DEFAULT_WINDOW_LENGTH = 5;

    // Register reset values
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = 11'd2;
    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 11'd400;

    // Register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DISTANCE = 1'b0,
        REG_MAX_DISTANCE = 1'b1
    } cfg_reg_t;

    // Conversion: dist = floor(dur * 5 / 291), using a reciprocal of 2^24 / 291
    // that undershoots by at most one, fixed by one compare and subtract.
    localparam int X_W         = DUR_W + 3;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP   = 16'd57653;
    localparam logic [X_W-1:0]     DIVISOR = 19'd291;

    // Result code for an empty window (-1)
    localparam logic [AVG_W-1:0] AVG_EMPTY = {AVG_W{1'b1}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic              accepted;
    } entry_t;

endpackage

/* design/ergma_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ergma_front: echo conversion and range gate
// Takes one echo duration, converts it to whole centimetres with a reciprocal
// multiply and one correction step, checks it against the gate limits and
// hands the classified request to the queue. Holds the limit registers.
// ----------------------------------------------------------------------------
module ergma_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ergma_pkg::DUR_W-1:0]     s_duration,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ergma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ergma_pkg::DIST_W-1:0]    cfg_wdata,
    output logic                            push_valid,
    input  logic                            push_ready,
    output ergma_pkg::entry_t               push_entry
);
    import ergma_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_QUO,
        ST_GATE
    } state_t;

    state_t              state_reg;
    logic [X_W-1:0]      x_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIST_W-1:0]   q_reg;
    logic [X_W-1:0]      rem_reg;
    logic [DIST_W-1:0]   min_reg;
    logic [DIST_W-1:0]   max_reg;

    logic [DIST_W-1:0]   q_est;
    logic [DIST_W-1:0]   dist_cm;

    // Estimate from the product, then correct by one where the remainder overflows
    assign q_est   = prod_reg[RECIP_SHIFT +: DIST_W];
    assign dist_cm = (rem_reg >= DIVISOR) ? q_reg + DIST_W'(1) : q_reg;

    assign s_tready            = (state_reg == ST_IDLE);
    assign cfg_ready           = 1'b1;
    assign push_valid          = (state_reg == ST_GATE);
    assign push_entry.dist_cm  = dist_cm;
    assign push_entry.accepted = (dist_cm >= min_reg) && (dist_cm <= max_reg);

    // Limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_DIST_RESET;
            max_reg <= MAX_DIST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_DISTANCE: min_reg <= cfg_wdata;
                REG_MAX_DISTANCE: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequence one request through multiply, estimate and gate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= {s_duration, 2'b00} + X_W'(s_duration);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(x_reg) * PROD_W'(RECIP);
                    state_reg <= ST_QUO;
                end
                ST_QUO: begin
                    q_reg     <= q_est;
                    rem_reg   <= x_reg - DIVISOR * X_W'(q_est);
                    state_reg <= ST_GATE;
                end
                ST_GATE: begin
                    if (push_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/ergma_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ergma_fifo: short queue between front and back
// Holds classified requests so the front can take the next echo while the
// back is still averaging or waiting on the receiver.
// ----------------------------------------------------------------------------
module ergma_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  ergma_pkg::entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ergma_pkg::entry_t pop_entry
);
    import ergma_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* design/ergma_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ergma_back: window store, sum pass and divider
// Writes gated distances into the ring, sums the filled slots one per cycle,
// divides by the filled count one quotient bit per cycle (-1 if none) and
// holds the result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ergma_back #(
    parameter int WINDOW_LENGTH = ergma_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  ergma_pkg::entry_t           pop_entry,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ergma_pkg::AVG_W-1:0] m_average,
    output logic                        m_accepted
);
    import ergma_pkg::*;

    localparam int POS_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [DIST_W-1:0]        slots [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] filled_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         idx_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [AVG_W-1:0]         avg_reg;
    logic                     acc_reg;
    logic                     m_valid_reg;

    logic [CNT_W:0]           trial;
    logic [CNT_W:0]           diff;
    logic                     fits;
    logic [SUM_W-1:0]         quo_next;
    logic                     store;

    // One restoring divide step
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, cnt_reg};
    assign fits     = (trial >= {1'b0, cnt_reg});
    assign quo_next = {quo_reg[SUM_W-2:0], fits};

    assign store      = (state_reg == ST_IDLE) && pop_valid && pop_entry.accepted;
    assign pop_ready  = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_average  = avg_reg;
    assign m_accepted = acc_reg;

    // Write the ring
    always_ff @(posedge aclk) begin
        if (store) begin
            slots[pos_reg] <= pop_entry.dist_cm;
        end
    end

    // Sequence store, sum, divide and output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        acc_reg <= pop_entry.accepted;
                        if (pop_entry.accepted) begin
                            filled_reg[pos_reg] <= 1'b1;
                            pos_reg <= (pos_reg == POS_W'(WINDOW_LENGTH - 1)) ? '0
                                                                            : pos_reg + POS_W'(1);
                        end
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (filled_reg[idx_reg]) begin
                        sum_reg <= sum_reg + SUM_W'(slots[idx_reg]);
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (idx_reg == POS_W'(WINDOW_LENGTH - 1)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        idx_reg <= idx_reg + POS_W'(1);
                    end
                end
                ST_FIN: begin
                    if (cnt_reg == '0) begin
                        avg_reg     <= AVG_EMPTY;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else begin
                        quo_reg   <= sum_reg;
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    quo_reg  <= quo_next;
                    rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        avg_reg     <= AVG_W'(quo_next[DIST_W-1:0]);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* design/echo_range_gated_moving_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_gated_moving_average: range gated moving average of echo ranges
// Converts echo durations to centimetres, keeps gated readings in a ring and
// reports the truncated mean of the filled slots (-1 if none) for every reading.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one echo duration in microseconds per request (s_tdata).
//   m_ channel: one result per request; m_tdata carries the average in cm
//     (two's complement, -1 while the window is empty), m_tuser is set when
//     the reading passed the gate and was stored.
//   cfg channel: index 0 writes the minimum distance, index 1 the maximum;
//     write only while the block is idle. cfg_ready is always high.
// Path: the front multiplies, estimates and gates, the queue registers the
//   request, and the back sums every slot and divides by the filled count
//   over SUM_W = 11 + clog2(WINDOW_LENGTH + 1) quotient bits; there is no
//   divide while the window is empty.
// The back takes no new request until it has passed its result on, through
//   its slot-per-cycle sum pass and its bit-per-cycle divider; the front
//   and a two-deep queue take following echoes meanwhile.
// Reset: the window is emptied, the write position goes to slot 0 and the
//   limits return to 2 and 400 cm.
// Stall: a held result keeps m_tvalid high; the queue fills and then the
//   front drops s_tready until the receiver takes the result.
// ----------------------------------------------------------------------------
module echo_range_gated_moving_average #(
    parameter int WINDOW_LENGTH = ergma_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ergma_pkg::TDATA_IN_W-1:0]  s_tdata,   // [15:0] echo_duration_us
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ergma_pkg::TDATA_OUT_W-1:0] m_tdata,   // [11:0] average_cm, [15:12] zero
    output logic                              m_tuser,   // [0] sample_accepted
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ergma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ergma_pkg::DIST_W-1:0]      cfg_wdata
);
    import ergma_pkg::*;

    logic             push_valid;
    logic             push_ready;
    entry_t           push_entry;
    logic             pop_valid;
    logic             pop_ready;
    entry_t           pop_entry;
    logic [AVG_W-1:0] average;

    // Convert and gate
    ergma_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_duration (s_tdata[DUR_W-1:0]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouple front from back
    ergma_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Store, sum and divide
    ergma_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_average  (average),
        .m_accepted (m_tuser)
    );

    assign m_tdata = {{(TDATA_OUT_W - AVG_W){1'b0}}, average};

    // Reset drops any pending result
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stored reading means the window cannot be empty
    a_accepted_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[AVG_W-1:0] != AVG_EMPTY)
        else $error("accepted reading reported with empty window");

    // Front holds its request while the queue is full
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && !push_ready |=> push_valid && $stable(push_entry))
        else $error("front dropped or changed a pending request");

    // Front takes no echo while a request waits for the queue
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !s_tready)
        else $error("front ready while request pending");

endmodule
